// ===== sv/keyed_slot_table_top_assert.svh =====
// Assertion macros used by the port-level checker of the keyed slot table.
`ifndef KEYED_SLOT_TABLE_TOP_ASSERT_SVH
`define KEYED_SLOT_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define KST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define KST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/kst_pkg.sv =====
// Shared types and constants of the keyed slot table.
`default_nettype none

package kst_pkg;

    localparam int SLOTS_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int OP_W       = 3;
    localparam int KEY_W      = 8;
    localparam int PAY_W      = 32;
    localparam int POS_W      = 8;
    localparam int SLOT_OUT_W = 4;
    localparam int OCC_OUT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_UPSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_NTH    = 3'd3,
        OP_READ   = 3'd4
    } kst_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_ACT,
        ST_RESP
    } kst_state_t;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_ITEM,
        SRC_MEM
    } kst_src_t;

    typedef struct packed {
        logic key_rd;
        logic key_we;
        logic pay_rd;
        logic pay_we;
    } kst_mem_ctl_t;

endpackage

`default_nettype wire

// ===== sv/kst_store.sv =====
// Key and payload memories of the keyed slot table, with per-slot written bits.
`default_nettype none

module kst_store #(
    parameter int SLOTS        = kst_pkg::SLOTS_DEF,
    parameter int PAYLOAD_BITS = kst_pkg::PAYLOAD_BITS_DEF,
    parameter int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire kst_pkg::kst_mem_ctl_t      ctl,
    input  wire logic [SLOT_W-1:0]          rd_addr,
    input  wire logic [SLOT_W-1:0]          pay_rd_addr,
    input  wire logic [SLOT_W-1:0]          wr_addr,
    input  wire logic [kst_pkg::KEY_W-1:0]  key_wd,
    input  wire logic [PAYLOAD_BITS-1:0]    pay_wd,
    output logic      [kst_pkg::KEY_W-1:0]  key_rd_data,
    output logic      [PAYLOAD_BITS-1:0]    pay_rd_data
);
    import kst_pkg::*;

    logic [KEY_W-1:0]        key_mem [SLOTS];
    logic [PAYLOAD_BITS-1:0] pay_mem [SLOTS];
    logic [SLOTS-1:0]        valid_reg;
    logic                    vld_q_reg;
    logic [KEY_W-1:0]        key_q_reg;
    logic [PAYLOAD_BITS-1:0] pay_q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.key_we)
        begin
            key_mem[wr_addr] <= key_wd;
        end
        if (ctl.key_rd)
        begin
            key_q_reg <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pay_we)
        begin
            pay_mem[wr_addr] <= pay_wd;
        end
        if (ctl.pay_rd)
        begin
            pay_q_reg <= pay_mem[pay_rd_addr];
        end
    end

    // A slot never written since reset reads as an empty key.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (ctl.key_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.key_rd)
            begin
                vld_q_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign key_rd_data = vld_q_reg ? key_q_reg : '0;
    assign pay_rd_data = pay_q_reg;

endmodule

`default_nettype wire

// ===== sv/keyed_slot_table_top.sv =====
// Top level of the keyed slot table: sequencer, slot scan and result register.
//
// The block keeps a table of SLOTS slots, each holding an 8-bit key (zero means
// empty) and a payload. One input transfer carries one operation (upsert,
// remove, lookup, nth occupied, read slot) and produces exactly one output
// transfer with ok, the found key and payload, the slot index and the count of
// occupied slots after the operation.
// Both channels use valid/stall; a transfer happens on a clock edge with valid
// high and stall low. in_stall is high from the cycle after an accepted item
// until the sequencer returns to idle.
// Each item scans every slot of the key memory, one read per cycle through its
// single read port, then drains the read pipeline, writes back or reads the
// payload memory, and loads the result register. No new item is accepted
// until the sequencer has returned to idle.
// The result register decouples the two sides: a new item is accepted while the
// previous result still waits; when out_stall holds, the sequencer waits in its
// response step until the register frees up.
// Reset clears all control state and the per-slot written bits, so every slot
// reads as empty and the occupancy count is zero right after reset.
`default_nettype none

module keyed_slot_table_top #(
    parameter int SLOTS        = kst_pkg::SLOTS_DEF,
    parameter int PAYLOAD_BITS = kst_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [kst_pkg::OP_W-1:0]        operation,
    input  wire logic [kst_pkg::KEY_W-1:0]       key,
    input  wire logic [kst_pkg::PAY_W-1:0]       payload,
    input  wire logic [kst_pkg::POS_W-1:0]       position,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 ok,
    output logic      [kst_pkg::KEY_W-1:0]       found_key,
    output logic      [kst_pkg::PAY_W-1:0]       found_payload,
    output logic      [kst_pkg::SLOT_OUT_W-1:0]  slot_index,
    output logic      [kst_pkg::OCC_OUT_W-1:0]   occupied
);
    import kst_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [SLOT_W-1:0] LAST_ADDR = SLOT_W'(SLOTS - 1);

    kst_state_t              state_reg, state_next;
    logic [SLOT_W-1:0]       addr_reg, addr_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [SLOT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    hit_reg, hit_next;
    logic [SLOT_W-1:0]       hit_idx_reg, hit_idx_next;
    logic [KEY_W-1:0]        hit_key_reg, hit_key_next;
    logic                    empty_reg, empty_next;
    logic [SLOT_W-1:0]       empty_idx_reg, empty_idx_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        occ_reg, occ_next;
    logic                    pend_ok_reg, pend_ok_next;
    logic [KEY_W-1:0]        pend_key_reg, pend_key_next;
    logic [SLOT_W-1:0]       pend_slot_reg, pend_slot_next;
    kst_src_t                pend_src_reg, pend_src_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    ok_reg, ok_next;
    logic [KEY_W-1:0]        found_key_reg, found_key_next;
    logic [PAY_W-1:0]        found_payload_reg, found_payload_next;
    logic [SLOT_OUT_W-1:0]   slot_index_reg, slot_index_next;
    logic [OCC_OUT_W-1:0]    occupied_reg, occupied_next;

    kst_mem_ctl_t            mem_ctl;
    logic [SLOT_W-1:0]       wr_addr;
    logic [KEY_W-1:0]        key_wd;
    logic [KEY_W-1:0]        eff_key;
    logic [PAYLOAD_BITS-1:0] pay_rd_data;

    logic                    accept;
    logic                    load_out;
    logic                    cand;
    logic                    act_ok;
    logic                    act_grow;
    logic                    act_shrink;
    logic [SLOT_W-1:0]       act_slot;
    logic [63:0]             pay_in_ext;
    logic [63:0]             pay_out_ext;
    logic [15:0]             slot_ext;
    logic [15:0]             occ_ext;

    kst_store #(
        .SLOTS        (SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .SLOT_W       (SLOT_W)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (mem_ctl),
        .rd_addr     (addr_reg),
        .pay_rd_addr (hit_idx_reg),
        .wr_addr     (wr_addr),
        .key_wd      (key_wd),
        .pay_wd      (pay_reg),
        .key_rd_data (eff_key),
        .pay_rd_data (pay_rd_data)
    );

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_RESP) && (!out_valid_reg || !out_stall);

    // Does the slot whose key was just read answer this item?
    always_comb
    begin
        cand = 1'b0;
        case (op_reg)
            OP_UPSERT, OP_REMOVE, OP_LOOKUP:
                cand = (eff_key != '0) && (eff_key == key_reg);
            OP_NTH:
                cand = (eff_key != '0) && (CMP_W'(count_reg) == CMP_W'(pos_reg));
            OP_READ:
                cand = (eff_key != '0) && (CMP_W'(rd_idx_reg) == CMP_W'(pos_reg));
            default:
                cand = 1'b0;
        endcase
    end

    // Outcome of the scan, used in the write-back step.
    always_comb
    begin
        act_ok     = 1'b0;
        act_grow   = 1'b0;
        act_shrink = 1'b0;
        act_slot   = '0;
        case (op_reg)
            OP_UPSERT:
            begin
                if (key_reg != '0 && hit_reg)
                begin
                    act_ok   = 1'b1;
                    act_slot = hit_idx_reg;
                end
                else if (key_reg != '0 && empty_reg)
                begin
                    act_ok   = 1'b1;
                    act_grow = 1'b1;
                    act_slot = empty_idx_reg;
                end
            end
            OP_REMOVE:
            begin
                act_ok     = hit_reg;
                act_shrink = hit_reg;
                act_slot   = hit_reg ? hit_idx_reg : '0;
            end
            OP_LOOKUP, OP_NTH, OP_READ:
            begin
                act_ok   = hit_reg;
                act_slot = hit_reg ? hit_idx_reg : '0;
            end
            default:
            begin
                act_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign pay_in_ext = 64'(payload);
    assign slot_ext   = 16'(pend_slot_reg);
    assign occ_ext    = 16'(occ_reg);

    always_comb
    begin
        case (pend_src_reg)
            SRC_ITEM: pay_out_ext = 64'(pay_reg);
            SRC_MEM:  pay_out_ext = 64'(pay_rd_data);
            default:  pay_out_ext = '0;
        endcase
    end

    always_comb
    begin
        addr_next          = addr_reg;
        rd_vld_next        = 1'b0;
        rd_idx_next        = addr_reg;
        op_next            = op_reg;
        key_next           = key_reg;
        pay_next           = pay_reg;
        pos_next           = pos_reg;
        hit_next           = hit_reg;
        hit_idx_next       = hit_idx_reg;
        hit_key_next       = hit_key_reg;
        empty_next         = empty_reg;
        empty_idx_next     = empty_idx_reg;
        count_next         = count_reg;
        occ_next           = occ_reg;
        pend_ok_next       = pend_ok_reg;
        pend_key_next      = pend_key_reg;
        pend_slot_next     = pend_slot_reg;
        pend_src_next      = pend_src_reg;
        out_valid_next     = out_valid_reg;
        ok_next            = ok_reg;
        found_key_next     = found_key_reg;
        found_payload_next = found_payload_reg;
        slot_index_next    = slot_index_reg;
        occupied_next      = occupied_reg;
        mem_ctl            = '0;
        wr_addr            = act_slot;
        key_wd             = (op_reg == OP_UPSERT) ? key_reg : '0;

        if (accept)
        begin
            op_next    = operation;
            key_next   = key;
            pay_next   = pay_in_ext[PAYLOAD_BITS-1:0];
            pos_next   = position;
            addr_next  = '0;
            hit_next   = 1'b0;
            empty_next = 1'b0;
            count_next = '0;
        end

        if (state_reg == ST_SCAN)
        begin
            mem_ctl.key_rd = 1'b1;
            rd_vld_next    = 1'b1;
            addr_next      = addr_reg + SLOT_W'(1);
        end

        // Key data of the slot issued in the previous cycle.
        if (rd_vld_reg)
        begin
            if (cand && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = rd_idx_reg;
                hit_key_next = eff_key;
            end
            if (eff_key == '0 && !empty_reg)
            begin
                empty_next     = 1'b1;
                empty_idx_next = rd_idx_reg;
            end
            if (eff_key != '0)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (state_reg == ST_ACT)
        begin
            mem_ctl.key_we = act_ok && (op_reg == OP_UPSERT || op_reg == OP_REMOVE);
            mem_ctl.pay_we = act_ok && (op_reg == OP_UPSERT);
            mem_ctl.pay_rd = act_ok && (op_reg == OP_LOOKUP || op_reg == OP_NTH
                                        || op_reg == OP_READ);
            if (act_grow)
            begin
                occ_next = occ_reg + CNT_W'(1);
            end
            else if (act_shrink)
            begin
                occ_next = occ_reg - CNT_W'(1);
            end
            pend_ok_next   = act_ok;
            pend_slot_next = act_slot;
            if (!act_ok)
            begin
                pend_key_next = '0;
                pend_src_next = SRC_NONE;
            end
            else if (op_reg == OP_UPSERT)
            begin
                pend_key_next = key_reg;
                pend_src_next = SRC_ITEM;
            end
            else if (op_reg == OP_REMOVE)
            begin
                pend_key_next = key_reg;
                pend_src_next = SRC_NONE;
            end
            else
            begin
                pend_key_next = hit_key_reg;
                pend_src_next = SRC_MEM;
            end
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (load_out)
        begin
            out_valid_next     = 1'b1;
            ok_next            = pend_ok_reg;
            found_key_next     = pend_key_reg;
            found_payload_next = pay_out_ext[PAY_W-1:0];
            slot_index_next    = slot_ext[SLOT_OUT_W-1:0];
            occupied_next      = occ_ext[OCC_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            addr_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            empty_reg     <= 1'b0;
            count_reg     <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            rd_vld_reg    <= rd_vld_next;
            hit_reg       <= hit_next;
            empty_reg     <= empty_next;
            count_reg     <= count_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg        <= rd_idx_next;
        op_reg            <= op_next;
        key_reg           <= key_next;
        pay_reg           <= pay_next;
        pos_reg           <= pos_next;
        hit_idx_reg       <= hit_idx_next;
        hit_key_reg       <= hit_key_next;
        empty_idx_reg     <= empty_idx_next;
        pend_ok_reg       <= pend_ok_next;
        pend_key_reg      <= pend_key_next;
        pend_slot_reg     <= pend_slot_next;
        pend_src_reg      <= pend_src_next;
        ok_reg            <= ok_next;
        found_key_reg     <= found_key_next;
        found_payload_reg <= found_payload_next;
        slot_index_reg    <= slot_index_next;
        occupied_reg      <= occupied_next;
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign found_key     = found_key_reg;
    assign found_payload = found_payload_reg;
    assign slot_index    = slot_index_reg;
    assign occupied      = occupied_reg;

endmodule

`default_nettype wire

// ===== sv/kst_checker.sv =====
// Port-level checker of the keyed slot table and its bind to the top level.
`default_nettype none
`include "keyed_slot_table_top_assert.svh"

module kst_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic [kst_pkg::OP_W-1:0]        operation,
    input wire logic [kst_pkg::KEY_W-1:0]       key,
    input wire logic [kst_pkg::PAY_W-1:0]       payload,
    input wire logic [kst_pkg::POS_W-1:0]       position,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic                            ok,
    input wire logic [kst_pkg::KEY_W-1:0]       found_key,
    input wire logic [kst_pkg::PAY_W-1:0]       found_payload,
    input wire logic [kst_pkg::SLOT_OUT_W-1:0]  slot_index,
    input wire logic [kst_pkg::OCC_OUT_W-1:0]   occupied
);
    import kst_pkg::*;

    // A failed operation reports no entry at all.
    `KST_ASSERT_NOW(a_fail_clean, out_valid && !ok,
        found_key == '0 && found_payload == '0 && slot_index == '0,
        "failed result carries entry data")

    // A successful operation always names a nonzero key.
    `KST_ASSERT_NOW(a_ok_key, out_valid && ok, found_key != '0,
        "successful result with empty key")

    // One item at a time: the input stalls right after a transfer.
    `KST_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall,
        "input accepted while an item is in progress")

    // A stalled result stays put.
    `KST_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(ok) && $stable(found_key) && $stable(found_payload)
        && $stable(slot_index) && $stable(occupied),
        "stalled result changed")

endmodule

bind keyed_slot_table_top kst_checker u_kst_checker (.*);

`default_nettype wire

// ===== tb/sv/keyed_slot_table_checker.sv =====
// Checker that mirrors the keyed slot table and compares every result transfer.
`default_nettype none

module keyed_slot_table_checker #(
    parameter int SLOTS = kst_pkg::SLOTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire logic [kst_pkg::OP_W-1:0]       operation,
    input  wire logic [kst_pkg::KEY_W-1:0]      key,
    input  wire logic [kst_pkg::PAY_W-1:0]      payload,
    input  wire logic [kst_pkg::POS_W-1:0]      position,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire logic                           ok,
    input  wire logic [kst_pkg::KEY_W-1:0]      found_key,
    input  wire logic [kst_pkg::PAY_W-1:0]      found_payload,
    input  wire logic [kst_pkg::SLOT_OUT_W-1:0] slot_index,
    input  wire logic [kst_pkg::OCC_OUT_W-1:0]  occupied,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  results_checked,
    output int                                  hit_count,
    output int                                  full_rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    import kst_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic                  ok;
        logic [KEY_W-1:0]      key;
        logic [PAY_W-1:0]      payload;
        logic [SLOT_OUT_W-1:0] slot;
        logic [OCC_OUT_W-1:0]  occupied;
    } table_reply_t;

    logic [KEY_W-1:0] shadow_key     [SLOTS];
    logic [PAY_W-1:0] shadow_payload [SLOTS];
    int               shadow_count;
    table_reply_t     awaited_replies [$];

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("[%0t] result %0d: %s", $time, results_checked, what);
    endtask

    // Lowest slot holding the key, or -1. Key zero never matches.
    function automatic int slot_of_key(input logic [KEY_W-1:0] k);
        int hit;
        hit = -1;
        if (k != '0)
            for (int i = SLOTS - 1; i >= 0; i--)
                if (shadow_key[i] == k)
                    hit = i;
        return hit;
    endfunction

    // Applies one request to the shadow table and returns the reply it must produce.
    function automatic table_reply_t apply_table_op(input logic [OP_W-1:0]  op,
                                                    input logic [KEY_W-1:0] k,
                                                    input logic [PAY_W-1:0] p,
                                                    input logic [POS_W-1:0] pos);
        table_reply_t r;
        int           s;
        int           rank;
        logic         take;
        r    = '0;
        s    = -1;
        rank = 0;
        take = 1'b0;
        case (op)
            OP_UPSERT:
            begin
                if (k != '0)
                begin
                    s = slot_of_key(k);
                    if (s < 0)
                    begin
                        for (int i = SLOTS - 1; i >= 0; i--)
                            if (shadow_key[i] == '0)
                                s = i;
                        if (s >= 0)
                            shadow_count++;
                        else
                            full_rejects++;
                    end
                    if (s >= 0)
                    begin
                        shadow_key[s]     = k;
                        shadow_payload[s] = p;
                        r.ok              = 1'b1;
                        r.key             = k;
                        r.payload         = p;
                    end
                end
            end
            OP_REMOVE:
            begin
                s = slot_of_key(k);
                if (s >= 0)
                begin
                    shadow_key[s] = '0;
                    shadow_count--;
                    r.ok  = 1'b1;
                    r.key = k;
                end
            end
            OP_LOOKUP:
            begin
                s    = slot_of_key(k);
                take = 1'b1;
            end
            OP_NTH:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (shadow_key[i] != '0)
                    begin
                        if (rank == int'(pos) && s < 0)
                            s = i;
                        rank++;
                    end
                take = 1'b1;
            end
            OP_READ:
            begin
                if (int'(pos) < SLOTS && shadow_key[int'(pos)] != '0)
                    s = int'(pos);
                take = 1'b1;
            end
            default: ;
        endcase
        if (take && s >= 0)
        begin
            r.ok      = 1'b1;
            r.key     = shadow_key[s];
            r.payload = shadow_payload[s];
        end
        if (r.ok)
            r.slot = SLOT_OUT_W'(s);
        r.occupied = OCC_OUT_W'(shadow_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                shadow_key[i]     = '0;
                shadow_payload[i] = '0;
            end
            shadow_count = 0;
            awaited_replies.delete();
            pending = 0;
        end
        else
        begin
            // The result side is checked first, so a reply can never match a
            // request accepted on the same edge.
            if (out_valid && !out_stall)
            begin
                if (awaited_replies.size() == 0)
                begin
                    report_mismatch("result transfer with no request outstanding");
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    results_checked++;
                    if (ok !== want.ok)
                        report_mismatch($sformatf("ok %b, expected %b", ok, want.ok));
                    if (found_key !== want.key)
                        report_mismatch($sformatf("found_key %h, expected %h",
                                                  found_key, want.key));
                    if (found_payload !== want.payload)
                        report_mismatch($sformatf("found_payload %h, expected %h",
                                                  found_payload, want.payload));
                    if (slot_index !== want.slot)
                        report_mismatch($sformatf("slot_index %0d, expected %0d",
                                                  slot_index, want.slot));
                    if (occupied !== want.occupied)
                        report_mismatch($sformatf("occupied %0d, expected %0d",
                                                  occupied, want.occupied));
                    if (want.ok)
                        hit_count++;
                end
            end
            if (in_valid && !in_stall)
                awaited_replies.push_back(apply_table_op(operation, key,
                                                         payload, position));
            pending = awaited_replies.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_keyed_slot_table_top.sv =====
// Top of the keyed slot table testbench: clock, reset, request and result traffic, verdict.
`default_nettype none

module tb_keyed_slot_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kst_pkg::*;

    localparam int SLOT_COUNT    = SLOTS_DEF;
    localparam int RANDOM_ITEMS  = 1530;
    // Keys in one random segment come from a window wider than the table, so
    // upserts both hit existing entries and run the table full.
    localparam int KEY_POOL      = 24;
    localparam int HOLD_CYCLES   = 160;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int RUN_LIMIT_NS  = 8_000_000;

    // Operation codes past the last defined one; the block must treat them as no-ops.
    localparam logic [OP_W-1:0] OP_FIRST_UNKNOWN = OP_W'(int'(OP_READ) + 1);
    localparam logic [OP_W-1:0] OP_LAST_UNKNOWN  = '1;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       operation     = '0;
    logic [KEY_W-1:0]      key           = '0;
    logic [PAY_W-1:0]      payload       = '0;
    logic [POS_W-1:0]      position      = '0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic                  ok;
    logic [KEY_W-1:0]      found_key;
    logic [PAY_W-1:0]      found_payload;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [OCC_OUT_W-1:0]  occupied;

    int fail_count;
    int pending;
    int results_checked;
    int hit_count;
    int full_rejects;

    // When quiet is set neither side idles; hold_pending asks the result side
    // for one long hold-off.
    bit quiet        = 1'b0;
    bit hold_pending = 1'b0;
    int op_tally [1 << OP_W];

    keyed_slot_table_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .key           (key),
        .payload       (payload),
        .position      (position),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ok            (ok),
        .found_key     (found_key),
        .found_payload (found_payload),
        .slot_index    (slot_index),
        .occupied      (occupied)
    );

    keyed_slot_table_checker #(
        .SLOTS (SLOT_COUNT)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .key             (key),
        .payload         (payload),
        .position        (position),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .ok              (ok),
        .found_key       (found_key),
        .found_payload   (found_payload),
        .slot_index      (slot_index),
        .occupied        (occupied),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .hit_count       (hit_count),
        .full_rejects    (full_rejects)
    );

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Safety net: the slowest legal run needs well under a quarter of this.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("keyed_slot_table_top verification failed");
        $finish;
    end

    // Offers one request and returns on the edge where the transfer happens.
    // A random gap before the request lands anywhere in the block's scan,
    // since the gap length spans a full item time. Valid is lowered and raised
    // again only on different edges, and the payload holds while stalled.
    task automatic offer_request(input logic [OP_W-1:0]  op,
                                 input logic [KEY_W-1:0] k,
                                 input logic [PAY_W-1:0] p,
                                 input logic [POS_W-1:0] pos);
        if (!quiet && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, SLOT_COUNT + 6)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        key       <= k;
        payload   <= p;
        position  <= pos;
        do
            @(posedge clk);
        while (in_stall);
        op_tally[op]++;
    endtask

    // Result side. Stall is decided per cycle, with a chance of about one in four,
    // except in the quiet stretch. On request it holds off once, with the length
    // of the hold counted here, so that the result register and the sequencer back
    // up and the input side sees in_stall for a long time while requests keep coming.
    initial
    begin
        int held;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                held         = 0;
                out_stall   <= 1'b1;
                while (held < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
            end
            else
            begin
                out_stall <= !quiet && ($urandom_range(0, 99) < 25);
            end
        end
    end

    initial
    begin
        int               sel;
        int               upsert_share;
        int               key_base;
        int               drain_cycles;
        int               unknown_ops;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] k;
        logic [POS_W-1:0] pos;

        upsert_share = 50;
        key_base     = 1;

        // Reset is asserted once, at the start of the run.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests. Key zero is rejected by every keyed operation, and
        // the empty table answers nothing.
        offer_request(OP_UPSERT, 8'd0, 32'hFFFF_FFFF, 8'd0);
        offer_request(OP_REMOVE, 8'd0, 32'h0000_0000, 8'd0);
        offer_request(OP_LOOKUP, 8'd0, 32'h0000_0000, 8'd0);
        offer_request(OP_NTH,    8'd0, 32'h0000_0000, 8'd0);
        offer_request(OP_READ,   8'd0, 32'h0000_0000, 8'd0);
        // Fill two slots with extreme keys and payloads, then overwrite one.
        offer_request(OP_UPSERT, 8'd255, 32'hFFFF_FFFF, 8'd0);
        offer_request(OP_UPSERT, 8'd1,   32'h0000_0000, 8'd255);
        offer_request(OP_UPSERT, 8'd255, 32'hA5A5_5A5A, 8'd0);
        offer_request(OP_LOOKUP, 8'd255, 32'h0000_0000, 8'd0);
        offer_request(OP_LOOKUP, 8'd128, 32'h0000_0000, 8'd0);
        // Ordinals: the last occupied entry, one past it, and the largest value.
        offer_request(OP_NTH,    8'd0, 32'h0000_0000, 8'd1);
        offer_request(OP_NTH,    8'd0, 32'h0000_0000, 8'd2);
        offer_request(OP_NTH,    8'd0, 32'h0000_0000, 8'd255);
        // Slot reads outside the table and of an empty slot.
        offer_request(OP_READ,   8'd0, 32'h0000_0000, 8'd255);
        offer_request(OP_READ,   8'd0, 32'h0000_0000, POS_W'(SLOT_COUNT - 1));
        // Remove, remove again once the key is gone, then read the freed slot.
        offer_request(OP_REMOVE, 8'd1, 32'hFFFF_FFFF, 8'd0);
        offer_request(OP_REMOVE, 8'd1, 32'h0000_0000, 8'd0);
        offer_request(OP_READ,   8'd0, 32'h0000_0000, 8'd1);
        // A new key must take the lowest free slot, the one just freed.
        offer_request(OP_UPSERT, 8'd2, 32'h1234_5678, 8'd0);
        // Undefined operation codes change nothing and report failure.
        offer_request(OP_FIRST_UNKNOWN, 8'd255, 32'hFFFF_FFFF, 8'd255);
        offer_request(OP_LAST_UNKNOWN,  8'd255, 32'hFFFF_FFFF, 8'd255);
        offer_request(OP_READ,   8'd0, 32'h0000_0000, 8'd0);

        // Random traffic in segments of 100 requests. Each segment draws a new
        // key window and a new upsert share, so some segments run the table
        // full while others drain it empty.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                key_base     = $urandom_range(1, 256 - KEY_POOL);
                upsert_share = $urandom_range(15, 70);
            end
            quiet = (n >= 700 && n < 950);
            if (n == 300 || n == 1200)
                hold_pending = 1'b1;

            sel = $urandom_range(0, 99);
            if (sel < upsert_share)
            begin
                op = OP_UPSERT;
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 35)
                    op = OP_REMOVE;
                else if (sel < 55)
                    op = OP_LOOKUP;
                else if (sel < 72)
                    op = OP_NTH;
                else if (sel < 94)
                    op = OP_READ;
                else
                    op = OP_W'($urandom_range(int'(OP_FIRST_UNKNOWN),
                                              int'(OP_LAST_UNKNOWN)));
            end

            // Mostly keys from the window, a few fully random ones and key zero.
            sel = $urandom_range(0, 99);
            if (sel < 3)
                k = '0;
            else if (sel < 10)
                k = KEY_W'($urandom_range(0, 255));
            else
                k = KEY_W'(key_base + $urandom_range(0, KEY_POOL - 1));

            // Ordinals mostly up to just past the table size, slot numbers mostly inside the table.
            sel = $urandom_range(0, 99);
            if (op == OP_NTH && sel < 90)
                pos = POS_W'($urandom_range(0, SLOT_COUNT + 1));
            else if (op == OP_READ && sel < 90)
                pos = POS_W'($urandom_range(0, SLOT_COUNT - 1));
            else
                pos = POS_W'($urandom_range(0, 255));

            offer_request(op, k, $urandom(), pos);
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        // Drain: wait for every outstanding result, then let the block settle.
        drain_cycles = 0;
        while (pending != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (SLOT_COUNT + 8) @(posedge clk);

        unknown_ops = 0;
        for (int i = int'(OP_FIRST_UNKNOWN); i <= int'(OP_LAST_UNKNOWN); i++)
            unknown_ops += op_tally[i];
        $display("Requests: %0d upsert, %0d remove, %0d lookup, ",
                 op_tally[OP_UPSERT], op_tally[OP_REMOVE], op_tally[OP_LOOKUP],
                 "%0d nth, %0d slot read, %0d undefined.",
                 op_tally[OP_NTH], op_tally[OP_READ], unknown_ops);
        $display("Results compared: %0d, of which %0d found or written; ",
                 results_checked, hit_count,
                 "%0d upserts hit a full table.", full_rejects);

        if (fail_count == 0 && pending == 0)
        begin
            $display("keyed_slot_table_top verification clean");
        end
        else
        begin
            if (pending != 0)
                $display("%0d expected results never arrived", pending);
            $display("keyed_slot_table_top verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/kst_pkg.sv
sv/kst_store.sv
sv/keyed_slot_table_top.sv
sv/kst_checker.sv
tb/sv/keyed_slot_table_checker.sv
tb/sv/tb_keyed_slot_table_top.sv
